[hdl/swm_pkg.sv]
// Shared types and constants for the sliding window maximum filter.
`timescale 1ns / 1ps

package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int WS_W     = 7;

    localparam logic [WS_W-1:0]            WS_RESET   = 7'd3;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } swm_state_t;

    typedef struct packed {
        logic load;
        logic start;
    } swm_cmd_t;

endpackage

[hdl/swm_cell.sv]
// One cell of the window store: holds a sample, its arrival position, and a valid bit.
`timescale 1ns / 1ps

module swm_cell
    import swm_pkg::*;
#(
    parameter int IDX = 0,
    parameter int N   = 64,
    parameter int PW  = 7
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  swm_cmd_t                   cmd,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [PW-1:0]              pos_cur,
    input  logic [PW-1:0]              win,
    input  logic signed [SAMPLE_W-1:0] run_in,
    output logic signed [SAMPLE_W-1:0] run_out
);

    logic                       valid_reg;
    logic                       valid_next;
    logic signed [SAMPLE_W-1:0] value_reg;
    logic [PW-1:0]              position_reg;
    logic signed [SAMPLE_W-1:0] run_reg;
    logic signed [SAMPLE_W-1:0] run_next;
    logic                       hit;
    logic [PW:0]                age_wide;
    logic [PW-1:0]              age;
    logic                       expire;

    assign hit = (pos_cur == PW'(IDX)) || (pos_cur == PW'(IDX + N));

    // Age modulo 2N between this item's position and the stored one.
    always_comb
    begin
        if (pos_cur >= position_reg)
        begin
            age_wide = {1'b0, pos_cur} - {1'b0, position_reg};
        end
        else
        begin
            age_wide = {1'b0, pos_cur} + (PW+1)'(2 * N) - {1'b0, position_reg};
        end
        age    = age_wide[PW-1:0];
        expire = (age >= win) || (value_reg < sample);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.load)
        begin
            if (hit)
            begin
                valid_next = 1'b1;
            end
            else if (cmd.start || expire)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && hit)
        begin
            value_reg    <= sample;
            position_reg <= pos_cur;
        end
    end

    // Pass the running maximum on to the next cell.
    assign run_next = (valid_reg && (value_reg > run_in)) ? value_reg : run_in;

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
    end

    assign run_out = run_reg;

    a_hit_written: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && hit |=> valid_reg && (value_reg == $past(sample)))
        else $error("cell not written on its slot");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && cmd.start && !hit |=> !valid_reg)
        else $error("cell survived a sequence start");

endmodule

[hdl/swm_ctrl.sv]
// Sequencer: sample position, window fill flag, scan counter and result release.
`timescale 1ns / 1ps

module swm_ctrl
    import swm_pkg::*;
#(
    parameter int N  = 64,
    parameter int PW = 7
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            start_req,
    input  logic [WS_W-1:0] window_size,
    input  logic            out_free,
    output logic            in_ready,
    output swm_cmd_t        cmd,
    output logic [PW-1:0]   pos_cur,
    output logic [PW-1:0]   win,
    output logic            out_load
);

    localparam int CW = (N > 1) ? $clog2(N) : 1;

    swm_state_t     state_reg;
    swm_state_t     state_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic [PW-1:0]  pos_reg;
    logic [PW-1:0]  pos_next;
    logic           filled_reg;
    logic           filled_next;
    logic [PW:0]    pos_inc;

    // Effective window: zero reads as one, saturate at the store depth.
    always_comb
    begin
        if (window_size == '0)
        begin
            win = PW'(1);
        end
        else if (32'(window_size) > 32'(N))
        begin
            win = PW'(N);
        end
        else
        begin
            win = PW'(window_size);
        end
    end

    assign pos_cur = start_req ? '0 : pos_reg;
    assign pos_inc = {1'b0, pos_cur} + (PW+1)'(1);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        filled_next = filled_reg;
        in_ready    = 1'b0;
        out_load    = 1'b0;
        cmd.load    = 1'b0;
        cmd.start   = start_req;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    cnt_next    = CW'(N - 1);
                    state_next  = ST_SCAN;
                    filled_next = (filled_reg && !start_req) || (pos_inc >= {1'b0, win});
                    pos_next    = (pos_inc == (PW+1)'(2 * N)) ? '0 : pos_inc[PW-1:0];
                end
            end
            ST_SCAN:
            begin
                // Wait for the running maximum to reach the tail of the chain.
                if (cnt_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!filled_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            pos_reg    <= '0;
            filled_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
            filled_reg <= filled_next;
        end
    end

    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_SCAN)
        else $error("accepted item did not start a scan");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && cnt_reg == '0 |=> state_reg == ST_DRAIN)
        else $error("scan did not end after the chain length");

    a_load_filled: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> filled_reg && state_reg == ST_DRAIN && out_free)
        else $error("result released before the window filled");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < 32'(2 * N))
        else $error("sample position out of range");

endmodule

[hdl/sliding_window_max_top.sv]
// Top level of the sliding window maximum filter: config register, cell chain, output register.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------------
//  config    | window_size_we          | window_size[6:0]
//  input     | in_valid / in_ready     | sample[31:0] signed, start_req
//  output    | out_valid / out_ready   | window_max[31:0] signed
//
// On acceptance every cell is updated in parallel, then the running maximum walks
// the chain of WINDOW_MAX cells one cell per cycle, and the release step hands it,
// once the window has filled, to the output register; no new item is taken until then.
// A waiting result holds the block in its release step until out_ready.
// Reset clears all valid bits, the sample position and the fill flag at once.
`timescale 1ns / 1ps

module sliding_window_max_top
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       window_size_we,
    input  logic [WS_W-1:0]            window_size,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       start_req,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] window_max
);

    localparam int PW = $clog2(2 * WINDOW_MAX);

    logic [WS_W-1:0]            window_size_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] window_max_reg;
    swm_cmd_t                   cmd;
    logic [PW-1:0]              pos_cur;
    logic [PW-1:0]              win;
    logic                       out_load;
    logic                       out_free;
    logic signed [SAMPLE_W-1:0] run [0:WINDOW_MAX];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WS_RESET;
        end
        else if (window_size_we)
        begin
            window_size_reg <= window_size;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    swm_ctrl #(
        .N  (WINDOW_MAX),
        .PW (PW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .start_req   (start_req),
        .window_size (window_size_reg),
        .out_free    (out_free),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .pos_cur     (pos_cur),
        .win         (win),
        .out_load    (out_load)
    );

    // Seed the chain with the smallest value; the new sample always sits in its cell.
    assign run[0] = SAMPLE_MIN;

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        swm_cell #(
            .IDX (i),
            .N   (WINDOW_MAX),
            .PW  (PW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .sample  (sample),
            .pos_cur (pos_cur),
            .win     (win),
            .run_in  (run[i]),
            .run_out (run[i+1])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            window_max_reg <= run[WINDOW_MAX];
        end
    end

    assign out_valid  = out_valid_reg;
    assign window_max = window_max_reg;

endmodule

[dv/tb_sliding_window_max_top.sv]
// Testbench for the sliding window maximum filter: directed rows, then random phases.
`timescale 1ns / 1ps

module tb_sliding_window_max_top
    import swm_pkg::*;
();

    localparam int DEPTH        = 64;
    localparam int POS_SPAN     = 2 * DEPTH;
    localparam int DRAIN_WAIT   = DEPTH + 8;
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int SHOWN_ERRORS = 10;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7fff_ffff;
    localparam logic [WS_W-1:0]            WIN_ZERO   = '0;
    localparam logic [WS_W-1:0]            WIN_ONE    = WS_W'(1);
    localparam logic [WS_W-1:0]            WIN_FULL   = WS_W'(DEPTH);
    localparam logic [WS_W-1:0]            WIN_TOP    = '1;

    typedef struct {
        bit                         cfg_now;
        logic [WS_W-1:0]            cfg_val;
        logic signed [SAMPLE_W-1:0] smp;
        bit                         first;
        bit                         typed;
        logic signed [SAMPLE_W-1:0] want;
    } stim_row_t;

    logic                       clk            = 1'b0;
    logic                       rst_n          = 1'b0;
    logic                       window_size_we = 1'b0;
    logic [WS_W-1:0]            window_size    = WS_RESET;
    logic                       in_valid       = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample         = '0;
    logic                       start_req      = 1'b0;
    logic                       out_valid;
    logic                       out_ready      = 1'b0;
    logic signed [SAMPLE_W-1:0] window_max;

    // predictor state
    logic [WS_W-1:0]            win_setting;
    logic signed [SAMPLE_W-1:0] held_val [DEPTH];
    int                         held_pos [DEPTH];
    bit                         held_live [DEPTH];
    int                         next_pos;
    bit                         window_full;

    logic signed [SAMPLE_W-1:0] pending_max [$];
    stim_row_t                  stim_rows [$];
    int                         mismatches = 0;
    int                         burst_left = 0;
    int                         quiet_cycles = 0;
    int                         ready_run = 0;
    int                         stall_run = 0;

    sliding_window_max_top #(
        .WINDOW_MAX(DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .window_size_we (window_size_we),
        .window_size    (window_size),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .start_req      (start_req),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .window_max     (window_max)
    );

    always #5 clk = ~clk;

    function automatic int span_of(input logic [WS_W-1:0] w);
        if (w == WIN_ZERO)
            return 1;
        if (int'(w) > DEPTH)
            return DEPTH;
        return int'(w);
    endfunction

    // Advance the store by one sample; returns 1 when a maximum comes out.
    function automatic bit next_window_max(input logic signed [SAMPLE_W-1:0] s, input bit first,
                                           output logic signed [SAMPLE_W-1:0] peak);
        int span;
        int pos;
        int age;
        span = span_of(win_setting);
        if (first)
        begin
            for (int i = 0; i < DEPTH; i++)
                held_live[i] = 1'b0;
            next_pos    = 0;
            window_full = 1'b0;
        end
        pos = next_pos;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (held_live[i])
            begin
                age = (pos + POS_SPAN - held_pos[i]) % POS_SPAN;
                if (age >= span || held_val[i] < s)
                    held_live[i] = 1'b0;
            end
        end
        held_val[pos % DEPTH]  = s;
        held_pos[pos % DEPTH]  = pos;
        held_live[pos % DEPTH] = 1'b1;
        if (pos + 1 >= span)
            window_full = 1'b1;
        next_pos = (pos + 1) % POS_SPAN;
        peak = s;
        if (!window_full)
            return 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (held_live[i] && held_val[i] > peak)
                peak = held_val[i];
        end
        return 1'b1;
    endfunction

    task automatic add_row(input bit cfg_now, input logic [WS_W-1:0] cfg_val,
                           input logic signed [SAMPLE_W-1:0] smp, input bit first,
                           input bit typed, input logic signed [SAMPLE_W-1:0] want);
        stim_row_t r;
        r.cfg_now = cfg_now;
        r.cfg_val = cfg_val;
        r.smp     = smp;
        r.first   = first;
        r.typed   = typed;
        r.want    = want;
        stim_rows = {stim_rows, r};
    endtask

    // Hold valid and payload until the item is taken, then log its expectation.
    task automatic push_item(input logic signed [SAMPLE_W-1:0] s, input bit first,
                             input bit typed, input logic signed [SAMPLE_W-1:0] want);
        logic signed [SAMPLE_W-1:0] peak;
        bit                         got;
        in_valid  <= 1'b1;
        sample    <= s;
        start_req <= first;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        got = next_window_max(s, first, peak);
        if (typed)
            pending_max = {pending_max, want};
        else if (got)
            pending_max = {pending_max, peak};
    endtask

    task automatic sender_pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Let every expected maximum arrive, then give an item with no result time to finish.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_max.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_window(input logic [WS_W-1:0] w);
        wait_drained();
        window_size    <= w;
        window_size_we <= 1'b1;
        @(posedge clk);
        window_size_we <= 1'b0;
        win_setting = w;
    endtask

    // Output side: stall in runs of random length, now and then long ones.
    always @(posedge clk)
    begin : rx_pace
        bit rdy;
        if (ready_run > 0)
        begin
            ready_run--;
            rdy = 1'b1;
        end
        else if (stall_run > 0)
        begin
            stall_run--;
            rdy = 1'b0;
        end
        else
        begin
            ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                    : $urandom_range(0, 30);
            stall_run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150)
                                                    : $urandom_range(0, 8);
            rdy = (stall_run == 0);
        end
        out_ready <= rdy;
    end

    always @(posedge clk)
    begin : result_check
        logic signed [SAMPLE_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_max.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected window_max %0d at %0t", window_max, $realtime);
            end
            else
            begin
                want = pending_max[0];
                pending_max.delete(0);
                if (window_max !== want)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("window_max mismatch at %0t: expected %0d, got %0d",
                                 $realtime, want, window_max);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_sliding_window_max_top failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [WS_W-1:0]            w;
        logic signed [SAMPLE_W-1:0] s;
        logic signed [SAMPLE_W-1:0] prev;
        bit                         first;
        bit                         fresh;
        bit                         noisy;
        int                         span;
        int                         n;
        int                         style;
        int                         sent;

        win_setting = WS_RESET;
        for (int i = 0; i < DEPTH; i++)
            held_live[i] = 1'b0;
        next_pos    = 0;
        window_full = 1'b0;

        // window of 3 after reset: the first two samples give nothing
        add_row(0, WS_RESET, 32'sd5, 0, 0, 0);
        add_row(0, WS_RESET, -32'sd3, 0, 0, 0);
        add_row(0, WS_RESET, 32'sd7, 0, 1, 32'sd7);
        add_row(0, WS_RESET, SAMPLE_MIN, 0, 1, 32'sd7);
        add_row(0, WS_RESET, SAMPLE_MAX, 0, 1, SAMPLE_MAX);
        add_row(0, WS_RESET, SAMPLE_MIN, 0, 1, SAMPLE_MAX);
        add_row(0, WS_RESET, SAMPLE_MIN, 0, 1, SAMPLE_MAX);
        add_row(0, WS_RESET, SAMPLE_MIN, 0, 1, SAMPLE_MIN);
        add_row(0, WS_RESET, -32'sd7, 0, 1, -32'sd7);
        // new sequence, then shrink the window mid-sequence
        add_row(0, WS_RESET, 32'sd0, 1, 0, 0);
        add_row(1, WIN_ONE, -32'sd1, 0, 0, 0);
        add_row(0, WIN_ONE, -32'sd2, 0, 1, -32'sd2);
        // zero window acts as one
        add_row(1, WIN_ZERO, 32'sd42, 1, 1, 32'sd42);
        add_row(0, WIN_ZERO, -32'sd42, 0, 1, -32'sd42);
        // oversize window saturates; then shrink and grow mid-sequence
        add_row(1, WIN_TOP, 32'sd3, 1, 0, 0);
        add_row(0, WIN_TOP, 32'sd1, 0, 0, 0);
        add_row(1, WS_W'(2), 32'sd2, 0, 0, 0);
        add_row(1, WS_W'(5), 32'sd0, 0, 0, 0);
        add_row(0, WS_W'(5), -32'sd5, 0, 0, 0);
        add_row(0, WS_W'(5), 32'sd9, 1, 0, 0);
        add_row(0, WS_W'(5), 32'sd8, 0, 0, 0);
        add_row(0, WS_W'(5), 32'sd8, 0, 0, 0);
        add_row(0, WS_W'(5), 32'sd8, 0, 0, 0);
        add_row(0, WS_W'(5), SAMPLE_MIN, 0, 0, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].cfg_now)
                set_window(stim_rows[i].cfg_val);
            sender_pace();
            push_item(stim_rows[i].smp, stim_rows[i].first, stim_rows[i].typed,
                      stim_rows[i].want);
        end

        sent = 0;
        prev = '0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       w = WIN_ZERO;
                1:       w = WIN_ONE;
                2:       w = WIN_FULL;
                3:       w = WIN_TOP;
                4:       w = WS_W'($urandom_range(DEPTH + 1, 126));
                5:       w = WS_W'($urandom_range(9, DEPTH - 1));
                default: w = WS_W'($urandom_range(2, 8));
            endcase
            set_window(w);
            span  = span_of(w);
            n     = (span >= 16) ? $urandom_range(span + 16, 2 * span + 20)
                                 : $urandom_range(8, 60);
            style = $urandom_range(0, 2);
            fresh = ($urandom_range(0, 1) == 1);
            noisy = ($urandom_range(0, 7) == 0);
            for (int k = 0; k < n; k++)
            begin
                // hold off now and then until the block has caught up
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
                if (k == 0 && fresh)
                    first = 1'b1;
                else if (noisy)
                    first = ($urandom_range(0, 3) == 0);
                else
                    first = ($urandom_range(0, 4 * span + 8) == 0);
                case ($urandom_range(0, 15))
                    0:       s = SAMPLE_MIN;
                    1:       s = SAMPLE_MAX;
                    default:
                    begin
                        if (style == 0)
                            s = $urandom;
                        else if (style == 1)
                            s = prev - $signed({1'b0, 2'($urandom_range(0, 3))});
                        else
                            s = $signed(32'($urandom_range(0, 6))) - 32'sd3;
                    end
                endcase
                prev = s;
                sender_pace();
                push_item(s, first, 1'b0, '0);
                sent++;
            end
        end

        in_valid <= 1'b0;
        while (pending_max.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && pending_max.size() == 0)
            $display("tb_sliding_window_max_top passed");
        else
            $display("tb_sliding_window_max_top failed");
        $finish;
    end

endmodule
